/* sv/cmt_pkg.sv */
package cmt_pkg;

  // Command codes carried in the cmd field of a request.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_SHIFT  = 2'd2;

  // Request payload.
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [7:0]         cell_type;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic       found;
    logic [7:0] stored_type;
    logic       table_full;
    logic [6:0] entries_used;
  } rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  kind;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;
    logic match;
    logic hit;
    logic search;
    logic shift;
    logic out_free;
  } ctrl_status_t;

endpackage

/* sv/cmt_ctrl.sv */
module cmt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  cmt_pkg::ctrl_status_t status,
  output cmt_pkg::ctrl_cmd_t    ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;
  logic   busy;
  logic   issue;

  // A read is issued while entries remain, for a shift, or for a search that has not yet hit or matched.
  always_comb begin
    issue = (state == ST_SCAN) && status.more &&
            (status.shift || (status.search && !status.hit && !status.match));
    ctrl.load   = (state == ST_IDLE) && req_valid && !rst;
    ctrl.issue  = issue;
    ctrl.commit = (state == ST_COMMIT) && status.out_free;
  end

  // The request channel is held off for the whole of a transaction.
  assign req_stall = busy | rst;

  // State register and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_SCAN;
            busy  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (!issue) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted without blocking the next one");

  a_commit_frees: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> !req_stall)
    else $error("request channel still blocked after commit");

  a_no_read_after_hit: assert property (@(posedge clk) disable iff (rst)
    ctrl.issue |-> !status.hit)
    else $error("table read issued after a search hit");

endmodule

/* sv/cmt_datapath.sv */
module cmt_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmt_pkg::req_t         req,
  input  cmt_pkg::ctrl_cmd_t    ctrl,
  output cmt_pkg::ctrl_status_t status,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output cmt_pkg::rsp_t         rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  cmt_pkg::entry_t mem [TABLE_DEPTH];

  cmt_pkg::req_t   key;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] ptr;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  cmt_pkg::entry_t  rd_data;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       hit_kind;

  logic            is_insert;
  logic            is_lookup;
  logic            is_shift;
  logic            search;
  logic            match;
  logic            append;
  logic            we;
  logic [IDX_W-1:0] waddr;
  cmt_pkg::entry_t wdata;

  // Decode of the held command and comparison of the entry just read.
  assign is_insert = (key.cmd == cmt_pkg::CMD_INSERT);
  assign is_lookup = (key.cmd == cmt_pkg::CMD_LOOKUP);
  assign is_shift  = (key.cmd == cmt_pkg::CMD_SHIFT);
  assign search    = is_insert || is_lookup;
  assign match     = rd_pend && search &&
                     (rd_data.x == key.coord_x) && (rd_data.y == key.coord_y);

  // A new coordinate is appended only while there is room.
  assign append     = ctrl.commit && is_insert && !hit && (count != DEPTH_CNT);
  assign count_next = append ? count + CNT_W'(1) : count;

  // Single write port: shift write-back, insert update or append.
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = rd_data;
    if (rd_pend && is_shift) begin
      we      = 1'b1;
      wdata.x = rd_data.x - key.coord_x;
      wdata.y = rd_data.y - key.coord_y;
    end else if (ctrl.commit && is_insert && hit) begin
      we    = 1'b1;
      waddr = hit_idx;
      wdata = '{x: key.coord_x, y: key.coord_y, kind: key.cell_type};
    end else if (append) begin
      we    = 1'b1;
      waddr = count[IDX_W-1:0];
      wdata = '{x: key.coord_x, y: key.coord_y, kind: key.cell_type};
    end
  end

  // Table memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.issue) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      count   <= count_next;
      rd_pend <= ctrl.issue;
      if (ctrl.load) begin
        ptr <= '0;
        hit <= 1'b0;
      end else begin
        if (ctrl.issue) begin
          ptr <= ptr + CNT_W'(1);
        end
        if (match && !hit) begin
          hit <= 1'b1;
        end
      end
      if (ctrl.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= req;
    end
    if (ctrl.issue) begin
      rd_idx <= ptr[IDX_W-1:0];
    end
    if (match && !hit) begin
      hit_idx  <= rd_idx;
      hit_kind <= rd_data.kind;
    end
    if (ctrl.commit) begin
      rsp.found        <= search && hit;
      rsp.stored_type  <= (is_lookup && hit) ? hit_kind : 8'd0;
      rsp.table_full   <= is_insert && !hit && (count == DEPTH_CNT);
      rsp.entries_used <= 7'(count_next);
    end
  end

  // Status towards the controller.
  always_comb begin
    status.more     = (ptr < count);
    status.match    = match;
    status.hit      = hit;
    status.search   = search;
    status.shift    = is_shift;
    status.out_free = !rsp_valid || !rsp_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  a_commit_idle_scan: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> !rd_pend)
    else $error("commit while a table read is outstanding");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && is_shift) |-> (CNT_W'(rd_idx) < count))
    else $error("shift write-back beyond the used entries");

endmodule

/* sv/coordinate_map_table.sv */
// Coordinate map table: a store of up to TABLE_DEPTH grid cells, each with a
// signed x,y coordinate and a type byte, searched in insertion order.
// Requests arrive on req (req_valid/req_stall) and carry a command: insert or
// update, lookup, or shift of every stored coordinate. Each request yields
// exactly one response on rsp (rsp_valid/rsp_stall), a transaction on each
// side completing when valid is high and stall is low.
// The request is taken in the idle state; the scan then reads the used entries
// in order through the single memory read port, a shift writing each one back
// and a search stopping once it hits; the commit state writes the response
// register and, for an insert, the table.
// One request is handled at a time; req_stall is high from acceptance until
// the response has been placed in the output register.
// A finished response waits in the output register while rsp_stall is high;
// the next request may be accepted meanwhile, but its commit waits until the
// register is free.
// Reset empties the table (entry count zero) and clears both channels; no
// clearing pass is needed, as entries beyond the count are never read.
module coordinate_map_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cmt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cmt_pkg::rsp_t rsp
);

  cmt_pkg::ctrl_cmd_t    ctrl;
  cmt_pkg::ctrl_status_t status;

  // Sequencer for the scan of each transaction.
  cmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  // Table memory, scan registers and response register.
  cmt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* verif/coordinate_map_table_test.sv */
module coordinate_map_table_test;

  localparam int MAP_DEPTH = 64;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1690;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 2 * MAP_DEPTH + 16;
  localparam int TIMEOUT_CYCLES = 1000000;

  // One row of the directed table: the request and, where it is obvious, the reply.
  typedef struct packed {
    cmt_pkg::req_t item;
    logic typed;
    cmt_pkg::rsp_t want;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cmt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cmt_pkg::rsp_t rsp;

  // Shadow copy of the table contents.
  logic [15:0] map_x [MAP_DEPTH];
  logic [15:0] map_y [MAP_DEPTH];
  logic [7:0] map_kind [MAP_DEPTH];
  int map_used = 0;

  cmt_pkg::rsp_t awaited[$];
  probe_t probes[$];
  int failures = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_wanted = 1'b0;

  coordinate_map_table #(
    .TABLE_DEPTH(MAP_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one command to the shadow table and returns the reply it should produce.
  function automatic cmt_pkg::rsp_t apply_map_command(cmt_pkg::req_t r);
    cmt_pkg::rsp_t res;
    int slot;
    int i;
    res = '0;
    slot = -1;
    if (r.cmd == cmt_pkg::CMD_INSERT || r.cmd == cmt_pkg::CMD_LOOKUP) begin
      for (i = 0; i < map_used; i++) begin
        if (slot < 0 && map_x[i] == r.coord_x && map_y[i] == r.coord_y) slot = i;
      end
    end
    case (r.cmd)
      cmt_pkg::CMD_INSERT: begin
        if (slot >= 0) begin
          map_kind[slot] = r.cell_type;
          res.found = 1'b1;
        end else if (map_used < MAP_DEPTH) begin
          map_x[map_used] = r.coord_x;
          map_y[map_used] = r.coord_y;
          map_kind[map_used] = r.cell_type;
          map_used++;
        end else begin
          res.table_full = 1'b1;
        end
      end
      cmt_pkg::CMD_LOOKUP: begin
        if (slot >= 0) begin
          res.found = 1'b1;
          res.stored_type = map_kind[slot];
        end
      end
      cmt_pkg::CMD_SHIFT: begin
        for (i = 0; i < map_used; i++) begin
          map_x[i] = map_x[i] - r.coord_x;
          map_y[i] = map_y[i] - r.coord_y;
        end
      end
      default: ;
    endcase
    res.entries_used = 7'(map_used);
    return res;
  endfunction

  function automatic probe_t probe(logic [1:0] cmd, int x, int y, int kind, bit typed,
                                   int found, int stype, int full, int used);
    probe_t p;
    p.item.cmd = cmd;
    p.item.coord_x = 16'(x);
    p.item.coord_y = 16'(y);
    p.item.cell_type = 8'(kind);
    p.typed = typed;
    p.want.found = 1'(found);
    p.want.stored_type = 8'(stype);
    p.want.table_full = 1'(full);
    p.want.entries_used = 7'(used);
    return p;
  endfunction

  // Random request: mostly coordinates already stored or from a small
  // neighbourhood, so that hits, updates and a full table all occur.
  function automatic cmt_pkg::req_t draw_request();
    cmt_pkg::req_t r;
    int roll;
    int pick;
    roll = $urandom_range(99);
    if (roll < 40) r.cmd = cmt_pkg::CMD_INSERT;
    else if (roll < 80) r.cmd = cmt_pkg::CMD_LOOKUP;
    else if (roll < 92) r.cmd = cmt_pkg::CMD_SHIFT;
    else r.cmd = CMD_SPARE;
    r.cell_type = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (r.cmd == cmt_pkg::CMD_SHIFT && roll < 70) begin
      r.coord_x = 16'(int'($urandom_range(6)) - 3);
      r.coord_y = 16'(int'($urandom_range(6)) - 3);
    end else if (r.cmd != cmt_pkg::CMD_SHIFT && roll < 50 && map_used > 0) begin
      pick = $urandom_range(map_used - 1);
      r.coord_x = map_x[pick];
      r.coord_y = map_y[pick];
      // A near miss now and then: same x, neighbouring y.
      if (roll < 8) r.coord_y = r.coord_y ^ 16'h0001;
    end else if (roll < 80) begin
      r.coord_x = 16'(int'($urandom_range(8)) - 4);
      r.coord_y = 16'(int'($urandom_range(8)) - 4);
    end else begin
      r.coord_x = 16'($urandom);
      r.coord_y = 16'($urandom);
    end
    return r;
  endfunction

  // Offers one transaction, holding it until accepted, then records the reply due.
  task automatic send_request(cmt_pkg::req_t item, bit typed, cmt_pkg::rsp_t want);
    cmt_pkg::rsp_t modelled;
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    modelled = apply_map_command(item);
    awaited.push_back(typed ? want : modelled);
    @(negedge clk);
  endtask

  // Request side: reset, the directed table, then the random run.
  initial begin : req_side
    int n;
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, 0, 0, 0, 1'b1, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_SHIFT, 1, 1, 0, 1'b1, 0, 0, 0, 0));
    probes.push_back(probe(CMD_SPARE, 0, 0, 0, 1'b1, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_INSERT, -32768, 32767, 255, 1'b1, 0, 0, 0, 1));
    probes.push_back(probe(cmt_pkg::CMD_INSERT, 32767, -32768, 0, 1'b1, 0, 0, 0, 2));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, -32768, 32767, 0, 1'b1, 1, 255, 0, 2));
    probes.push_back(probe(cmt_pkg::CMD_INSERT, -32768, 32767, 'h5A, 1'b1, 1, 0, 0, 2));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, -32768, 32767, 0, 1'b1, 1, 'h5A, 0, 2));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, 32767, 32767, 0, 1'b1, 0, 0, 0, 2));
    probes.push_back(probe(cmt_pkg::CMD_INSERT, -1, -1, 1, 1'b1, 0, 0, 0, 3));
    probes.push_back(probe(cmt_pkg::CMD_SHIFT, 1, -1, 0, 1'b1, 0, 0, 0, 3));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, 32767, -32768, 0, 1'b0, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, -2, 0, 0, 1'b0, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_SHIFT, -32768, -32768, 0, 1'b0, 0, 0, 0, 0));
    probes.push_back(probe(CMD_SPARE, -1, -1, 255, 1'b1, 0, 0, 0, 3));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, -32768, 32767, 0, 1'b0, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_INSERT, 0, 0, 'hA5, 1'b0, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_SHIFT, 0, 0, 0, 1'b0, 0, 0, 0, 0));
    probes.push_back(probe(cmt_pkg::CMD_LOOKUP, 0, 0, 0, 1'b0, 0, 0, 0, 0));

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (probes[i]) send_request(probes[i].item, probes[i].typed, probes[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Idling phases: none, sender gaps, receiver stalls, both, none again.
      case ((n / 150) % 5)
        1: begin send_gap_pct = 79; recv_stall_pct = 0; end
        2: begin send_gap_pct = 0; recv_stall_pct = 79; end
        3: begin send_gap_pct = 25; recv_stall_pct = 25; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      // Long receiver hold-off while requests keep coming, so the block backs up.
      if (n == 20 || n == 1220) hold_wanted = 1'b1;
      // Sender pauses until every outstanding reply has come back.
      if (n == 700 || n == 1400) begin
        req_valid <= 1'b0;
        while (awaited.size() != 0) @(negedge clk);
      end
      send_request(draw_request(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Reply side stall pattern, with an occasional long hold-off counted here.
  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_wanted) begin
        hold_left = LONG_HOLD;
        hold_wanted = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  // Compares every accepted reply with the oldest one due.
  always @(posedge clk) begin
    cmt_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited.size() == 0) begin
        $error("reply with none outstanding: %p", rsp);
        failures++;
      end else begin
        want = awaited.pop_front();
        if (rsp.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp.found);
          failures++;
        end
        if (rsp.stored_type !== want.stored_type) begin
          $error("stored_type: expected %0d, got %0d", want.stored_type, rsp.stored_type);
          failures++;
        end
        if (rsp.table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, rsp.table_full);
          failures++;
        end
        if (rsp.entries_used !== want.entries_used) begin
          $error("entries_used: expected %0d, got %0d", want.entries_used, rsp.entries_used);
          failures++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
